// File: hdl/wrr_pkg.sv
package wrr_pkg;

  localparam int MAX_SITES       = 4;
  localparam int SITE_COUNT_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int TAG_W      = 16;
  localparam int WEIGHT_W   = 16;
  localparam int SITE_IDX_W = 2;
  localparam int SITES_W    = 3;
  localparam int COPY_W     = 4;
  localparam int COUNT_W    = 6;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // quota compare: (j+1)*2*min against 2*w+min, j up to eight
  localparam int ACC_W      = 22;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SITES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3     = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED     = 3'd0,
    KIND_UNKNOWN_SITE = 3'd1,
    KIND_QUEUE_FULL   = 3'd2,
    KIND_RESPONSE     = 3'd3,
    KIND_ROUND_DONE   = 3'd4,
    KIND_NO_SITES     = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENQ_CHK,
    ST_ENQ_WR,
    ST_MIN,
    ST_SITE_INIT,
    ST_POP_CHK,
    ST_POP_RD,
    ST_POP_OUT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                  push;
    logic                  pop;
    logic                  rd;
    logic [SITE_IDX_W-1:0] site;
  } q_cmd_t;

endpackage

// File: hdl/wrr_if.sv
interface wrr_in_if;
  logic                               valid;
  logic                               ready;
  logic                               command;
  logic [wrr_pkg::TAG_W-1:0]          request_tag;
  logic [wrr_pkg::SITE_IDX_W-1:0]     site_index;
  logic [wrr_pkg::COPY_W-1:0]         copy_count;

  modport source (output valid, command, request_tag, site_index, copy_count, input ready);
  modport sink (input valid, command, request_tag, site_index, copy_count, output ready);
endinterface

interface wrr_out_if;
  logic                               valid;
  logic                               ready;
  logic [wrr_pkg::KIND_W-1:0]         kind;
  logic [wrr_pkg::TAG_W-1:0]          served_tag;
  logic [wrr_pkg::SITE_IDX_W-1:0]     served_site;
  logic [wrr_pkg::COUNT_W-1:0]        served_count;
  logic                               last;

  modport source (output valid, kind, served_tag, served_site, served_count, last,
                  input ready);
  modport sink (input valid, kind, served_tag, served_site, served_count, last,
                output ready);
endinterface

interface wrr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [wrr_pkg::CFG_IDX_W-1:0]      index;
  logic [wrr_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/wrr_alu.sv
module wrr_alu (
  input  logic [wrr_pkg::ACC_W-1:0] op_a_i,
  input  logic [wrr_pkg::ACC_W-1:0] op_b_i,
  output logic [wrr_pkg::ACC_W-1:0] sum_o,
  output logic                      le_o
);

  // one adder and one magnitude compare, shared by the min-weight scan, quota limit and pop steps of the sequencer
  assign sum_o = op_a_i + op_b_i;
  assign le_o  = (op_a_i <= op_b_i);

endmodule

// File: hdl/wrr_queue.sv
module wrr_queue #(
  parameter int SITE_COUNT  = wrr_pkg::SITE_COUNT_DEF,
  parameter int QUEUE_DEPTH = wrr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wrr_pkg::q_cmd_t                    cmd_i,
  input  logic [wrr_pkg::TAG_W-1:0]          tag_i,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   fill_o,
  output logic [wrr_pkg::TAG_W-1:0]          rdata_o
);

  localparam int SiteW   = (SITE_COUNT > 1) ? $clog2(SITE_COUNT) : 1;
  localparam int HeadW   = $clog2(QUEUE_DEPTH);
  localparam int FillW   = $clog2(QUEUE_DEPTH+1);
  localparam int SlotW   = FillW + 1;
  localparam int Entries = SITE_COUNT * QUEUE_DEPTH;
  localparam int AddrW   = $clog2(Entries);

  logic [wrr_pkg::TAG_W-1:0] mem_q [Entries];
  logic [wrr_pkg::TAG_W-1:0] rdata_q;
  logic [HeadW-1:0]          head_q [SITE_COUNT];
  logic [FillW-1:0]          fill_q [SITE_COUNT];

  logic [SiteW-1:0] sel;
  logic [HeadW-1:0] head_sel;
  logic [FillW-1:0] fill_sel;
  logic [SlotW-1:0] slot_sum;
  logic [HeadW-1:0] wslot;
  logic [AddrW:0]   base;
  logic [AddrW:0]   waddr_wide;
  logic [AddrW:0]   raddr_wide;
  logic [HeadW-1:0] head_next;

  assign sel      = cmd_i.site[SiteW-1:0];
  assign head_sel = head_q[sel];
  assign fill_sel = fill_q[sel];

  // tail slot wraps at the depth, which need not be a power of two
  assign slot_sum = SlotW'(head_sel) + SlotW'(fill_sel);
  always_comb begin
    if (slot_sum >= SlotW'(QUEUE_DEPTH)) begin
      wslot = HeadW'(slot_sum - SlotW'(QUEUE_DEPTH));
    end else begin
      wslot = HeadW'(slot_sum);
    end
  end

  assign base       = (AddrW+1)'(sel) * (AddrW+1)'(QUEUE_DEPTH);
  assign waddr_wide = base + (AddrW+1)'(wslot);
  assign raddr_wide = base + (AddrW+1)'(head_sel);

  assign head_next = (head_sel == HeadW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + HeadW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[waddr_wide[AddrW-1:0]] <= tag_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[raddr_wide[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SITE_COUNT; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (cmd_i.push) begin
      fill_q[sel] <= fill_sel + FillW'(1);
    end else if (cmd_i.pop) begin
      fill_q[sel] <= fill_sel - FillW'(1);
      head_q[sel] <= head_next;
    end
  end

  assign fill_o  = fill_sel;
  assign rdata_o = rdata_q;

endmodule

// File: hdl/wrr_ctrl.sv
module wrr_ctrl #(
  parameter int SITE_COUNT  = wrr_pkg::SITE_COUNT_DEF,
  parameter int QUEUE_DEPTH = wrr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  wrr_in_if.sink                             req,
  wrr_out_if.source                          rsp,
  input  logic [wrr_pkg::SITES_W-1:0]        nsites_i,
  input  logic [wrr_pkg::WEIGHT_W-1:0]       weight_i [wrr_pkg::MAX_SITES],
  output wrr_pkg::q_cmd_t                    q_cmd_o,
  output logic [wrr_pkg::TAG_W-1:0]          q_tag_o,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_fill_i,
  input  logic [wrr_pkg::TAG_W-1:0]          q_rdata_i
);

  localparam int FillW = $clog2(QUEUE_DEPTH+1);
  localparam int SumW  = ((FillW > wrr_pkg::COPY_W) ? FillW : wrr_pkg::COPY_W) + 1;
  localparam int AccW  = wrr_pkg::ACC_W;

  wrr_pkg::state_e state_q, state_d;

  logic [wrr_pkg::TAG_W-1:0]          tag_q, tag_d;
  logic [wrr_pkg::SITE_IDX_W-1:0]     site_q, site_d;
  logic [wrr_pkg::COPY_W-1:0]         copies_q, copies_d;
  logic [wrr_pkg::COPY_W-1:0]         cnt_q, cnt_d;
  logic [wrr_pkg::SITES_W-1:0]        s_q, s_d;
  logic [wrr_pkg::WEIGHT_W-1:0]       minw_q, minw_d;
  logic [AccW-1:0]                    limit_q, limit_d;
  logic [AccW-1:0]                    acc_q, acc_d;
  logic [wrr_pkg::COUNT_W-1:0]        total_q, total_d;
  wrr_pkg::kind_e                     pend_q, pend_d;

  logic                               out_valid_q, out_valid_d;
  wrr_pkg::kind_e                     out_kind_q, out_kind_d;
  logic [wrr_pkg::TAG_W-1:0]          out_tag_q, out_tag_d;
  logic [wrr_pkg::SITE_IDX_W-1:0]     out_site_q, out_site_d;
  logic [wrr_pkg::COUNT_W-1:0]        out_count_q, out_count_d;
  logic                               out_last_q, out_last_d;

  logic                               accept;
  logic                               out_free;
  logic [wrr_pkg::WEIGHT_W-1:0]       w_raw;
  logic [wrr_pkg::WEIGHT_W-1:0]       w_eff;
  logic [AccW-1:0]                    two_min;
  logic                               site_bad;
  logic                               too_full;
  logic                               sites_done;
  logic [AccW-1:0]                    alu_a, alu_b, alu_sum;
  logic                               alu_le;

  assign req.ready = (state_q == wrr_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid_q || rsp.ready;

  // zero weight counts as one
  assign w_raw      = weight_i[s_q[wrr_pkg::SITE_IDX_W-1:0]];
  assign w_eff      = (w_raw == '0) ? wrr_pkg::WEIGHT_W'(1) : w_raw;
  assign two_min    = AccW'(minw_q) << 1;
  assign sites_done = (s_q == nsites_i);
  assign site_bad   = (wrr_pkg::SITES_W'(site_q) >= nsites_i);
  assign too_full   = (SumW'(q_fill_i) + SumW'(copies_q)) > SumW'(QUEUE_DEPTH);

  wrr_alu u_alu (
    .op_a_i (alu_a),
    .op_b_i (alu_b),
    .sum_o  (alu_sum),
    .le_o   (alu_le)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wrr_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.command == wrr_pkg::CMD_ENQUEUE) begin
            state_d = wrr_pkg::ST_ENQ_CHK;
          end else if (nsites_i == '0) begin
            state_d = wrr_pkg::ST_EMIT;
          end else begin
            state_d = wrr_pkg::ST_MIN;
          end
        end
      end
      wrr_pkg::ST_ENQ_CHK: begin
        if (site_bad || too_full) begin
          state_d = wrr_pkg::ST_EMIT;
        end else begin
          state_d = wrr_pkg::ST_ENQ_WR;
        end
      end
      wrr_pkg::ST_ENQ_WR: begin
        if (cnt_q == copies_q) begin
          state_d = wrr_pkg::ST_EMIT;
        end
      end
      wrr_pkg::ST_MIN: begin
        if (sites_done) begin
          state_d = wrr_pkg::ST_SITE_INIT;
        end
      end
      wrr_pkg::ST_SITE_INIT: begin
        if (sites_done) begin
          state_d = wrr_pkg::ST_EMIT;
        end else begin
          state_d = wrr_pkg::ST_POP_CHK;
        end
      end
      wrr_pkg::ST_POP_CHK: begin
        if ((q_fill_i != '0) && alu_le) begin
          state_d = wrr_pkg::ST_POP_RD;
        end else begin
          state_d = wrr_pkg::ST_SITE_INIT;
        end
      end
      wrr_pkg::ST_POP_RD: begin
        state_d = wrr_pkg::ST_POP_OUT;
      end
      wrr_pkg::ST_POP_OUT: begin
        if (out_free) begin
          state_d = wrr_pkg::ST_POP_CHK;
        end
      end
      wrr_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = wrr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wrr_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    tag_d       = tag_q;
    site_d      = site_q;
    copies_d    = copies_q;
    cnt_d       = cnt_q;
    s_d         = s_q;
    minw_d      = minw_q;
    limit_d     = limit_q;
    acc_d       = acc_q;
    total_d     = total_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !rsp.ready;
    out_kind_d  = out_kind_q;
    out_tag_d   = out_tag_q;
    out_site_d  = out_site_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    q_cmd_o     = '{push: 1'b0, pop: 1'b0, rd: 1'b0, site: s_q[wrr_pkg::SITE_IDX_W-1:0]};
    q_tag_o     = tag_q;
    alu_a       = AccW'(w_eff);
    alu_b       = AccW'(minw_q);
    case (state_q)
      wrr_pkg::ST_IDLE: begin
        if (accept) begin
          tag_d    = req.request_tag;
          site_d   = req.site_index;
          copies_d = req.copy_count;
          s_d      = '0;
          minw_d   = '1;
          total_d  = '0;
          pend_d   = wrr_pkg::KIND_NO_SITES;
        end
      end
      wrr_pkg::ST_ENQ_CHK: begin
        q_cmd_o.site = site_q;
        cnt_d        = '0;
        if (site_bad) begin
          pend_d = wrr_pkg::KIND_UNKNOWN_SITE;
        end else if (too_full) begin
          pend_d = wrr_pkg::KIND_QUEUE_FULL;
        end else begin
          pend_d = wrr_pkg::KIND_ACCEPTED;
        end
      end
      wrr_pkg::ST_ENQ_WR: begin
        q_cmd_o.site = site_q;
        if (cnt_q != copies_q) begin
          q_cmd_o.push = 1'b1;
          cnt_d        = cnt_q + wrr_pkg::COPY_W'(1);
        end
      end
      wrr_pkg::ST_MIN: begin
        if (sites_done) begin
          s_d = '0;
        end else begin
          if (alu_le) begin
            minw_d = w_eff;
          end
          s_d = s_q + wrr_pkg::SITES_W'(1);
        end
      end
      wrr_pkg::ST_SITE_INIT: begin
        // limit = 2*w + min; the j-th pop is allowed while j*2*min <= limit
        alu_a   = AccW'(w_eff) << 1;
        alu_b   = AccW'(minw_q);
        limit_d = alu_sum;
        acc_d   = two_min;
        pend_d  = wrr_pkg::KIND_ROUND_DONE;
      end
      wrr_pkg::ST_POP_CHK: begin
        alu_a = acc_q;
        alu_b = limit_q;
        if (!((q_fill_i != '0) && alu_le)) begin
          s_d = s_q + wrr_pkg::SITES_W'(1);
        end
      end
      wrr_pkg::ST_POP_RD: begin
        q_cmd_o.rd = 1'b1;
      end
      wrr_pkg::ST_POP_OUT: begin
        alu_a = acc_q;
        alu_b = two_min;
        if (out_free) begin
          q_cmd_o.pop = 1'b1;
          acc_d       = alu_sum;
          total_d     = total_q + wrr_pkg::COUNT_W'(1);
          out_valid_d = 1'b1;
          out_kind_d  = wrr_pkg::KIND_RESPONSE;
          out_tag_d   = q_rdata_i;
          out_site_d  = s_q[wrr_pkg::SITE_IDX_W-1:0];
          out_count_d = '0;
          out_last_d  = 1'b0;
        end
      end
      wrr_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = pend_q;
          out_tag_d   = '0;
          out_site_d  = '0;
          out_count_d = (pend_q == wrr_pkg::KIND_ROUND_DONE) ? total_q : '0;
          out_last_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q       <= tag_d;
    site_q      <= site_d;
    copies_q    <= copies_d;
    cnt_q       <= cnt_d;
    s_q         <= s_d;
    minw_q      <= minw_d;
    limit_q     <= limit_d;
    acc_q       <= acc_d;
    total_q     <= total_d;
    pend_q      <= pend_d;
    out_kind_q  <= out_kind_d;
    out_tag_q   <= out_tag_d;
    out_site_q  <= out_site_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.kind         = out_kind_q;
  assign rsp.served_tag   = out_tag_q;
  assign rsp.served_site  = out_site_q;
  assign rsp.served_count = out_count_q;
  assign rsp.last         = out_last_q;

endmodule

// File: hdl/weighted_round_robin_dequeue.sv
// weighted round-robin dequeue
// req_i takes words: command 0 enqueues request_tag copy_count times into the
// fifo of site_index, command 1 runs one dequeue round over the active sites.
// rsp_o returns result words; the final word for each request has last set.
// cfg_i writes active_sites (index 0) and the four site weights (1..4); it is
// always ready, and the user must write it only while no request is in flight;
// the block itself does not enforce this. an accepted enqueue writes its copies
// and then gives its single result word; a rejected one, and a round with no
// active site, give a single word too. in a dequeue round the sequencer reuses
// one add/compare unit for the min-weight scan, the quota limit and the
// per-pop quota check, and the queue port takes one entry per cycle.
// req_i is not ready while a request is being worked on.
// results go through an output register: when rsp_o stalls the sequencer
// holds at its next result until the register frees up.
// reset empties all queues (head and fill cleared), sets active_sites to 0
// and every weight to 1; queue contents are not cleared.
module weighted_round_robin_dequeue #(
  parameter int SITE_COUNT  = wrr_pkg::SITE_COUNT_DEF,
  parameter int QUEUE_DEPTH = wrr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wrr_in_if.sink    req_i,
  wrr_out_if.source rsp_o,
  wrr_cfg_if.sink   cfg_i
);

  localparam int FillW = $clog2(QUEUE_DEPTH+1);

  logic [wrr_pkg::SITES_W-1:0]  active_q;
  logic [wrr_pkg::WEIGHT_W-1:0] weight_q [wrr_pkg::MAX_SITES];
  logic [wrr_pkg::SITES_W-1:0]  nsites;
  logic                         cfg_wr;

  wrr_pkg::q_cmd_t              q_cmd;
  logic [wrr_pkg::TAG_W-1:0]    q_tag;
  logic [FillW-1:0]             q_fill;
  logic [wrr_pkg::TAG_W-1:0]    q_rdata;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < wrr_pkg::MAX_SITES; i++) begin
        weight_q[i] <= wrr_pkg::WEIGHT_W'(1);
      end
    end else if (cfg_wr) begin
      case (cfg_i.index)
        wrr_pkg::REG_ACTIVE_SITES: active_q    <= cfg_i.data[wrr_pkg::SITES_W-1:0];
        wrr_pkg::REG_WEIGHT_0:     weight_q[0] <= cfg_i.data[wrr_pkg::WEIGHT_W-1:0];
        wrr_pkg::REG_WEIGHT_1:     weight_q[1] <= cfg_i.data[wrr_pkg::WEIGHT_W-1:0];
        wrr_pkg::REG_WEIGHT_2:     weight_q[2] <= cfg_i.data[wrr_pkg::WEIGHT_W-1:0];
        wrr_pkg::REG_WEIGHT_3:     weight_q[3] <= cfg_i.data[wrr_pkg::WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // more sites than built saturate to the built count
  assign nsites = (active_q > wrr_pkg::SITES_W'(SITE_COUNT)) ?
                  wrr_pkg::SITES_W'(SITE_COUNT) : active_q;

  wrr_ctrl #(
    .SITE_COUNT  (SITE_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .rsp       (rsp_o),
    .nsites_i  (nsites),
    .weight_i  (weight_q),
    .q_cmd_o   (q_cmd),
    .q_tag_o   (q_tag),
    .q_fill_i  (q_fill),
    .q_rdata_i (q_rdata)
  );

  wrr_queue #(
    .SITE_COUNT  (SITE_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (q_cmd),
    .tag_i   (q_tag),
    .fill_o  (q_fill),
    .rdata_o (q_rdata)
  );

endmodule

// File: test/weighted_round_robin_dequeue_test.sv
module weighted_round_robin_dequeue_test;
  import wrr_pkg::*;

  typedef struct packed {
    logic                  command;
    logic [TAG_W-1:0]      tag;
    logic [SITE_IDX_W-1:0] site;
    logic [COPY_W-1:0]     copies;
  } request_t;

  typedef struct packed {
    kind_e                 kind;
    logic [TAG_W-1:0]      tag;
    logic [SITE_IDX_W-1:0] site;
    logic [COUNT_W-1:0]    count;
    logic                  last;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wrr_in_if  req_if ();
  wrr_out_if rsp_if ();
  wrr_cfg_if cfg_if ();

  // stimulus side registers, known from time zero
  request_t              req_word  = '0;
  logic                  req_valid = 1'b0;
  logic                  rsp_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  assign req_if.valid       = req_valid;
  assign req_if.command     = req_word.command;
  assign req_if.request_tag = req_word.tag;
  assign req_if.site_index  = req_word.site;
  assign req_if.copy_count  = req_word.copies;
  assign rsp_if.ready       = rsp_ready;
  assign cfg_if.valid       = cfg_valid;
  assign cfg_if.index       = cfg_index;
  assign cfg_if.data        = cfg_data;

  weighted_round_robin_dequeue u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // scheduler state as the block should hold it
  logic [TAG_W-1:0] fifo_tag [MAX_SITES][QUEUE_DEPTH_DEF];
  int               fifo_head [MAX_SITES] = '{default: 0};
  int               fifo_fill [MAX_SITES] = '{default: 0};
  int               live_sites = 0;
  int               site_weight [MAX_SITES] = '{default: 1};

  request_t pending_requests [$];
  result_t  expected_words [$];
  result_t  want;
  int       errors = 0;
  logic     gaps_on = 1'b1;
  logic     stall_req = 1'b0;
  logic     stall_used = 1'b0;
  int       stall_left = 0;

  function automatic void push_word(kind_e k, logic [TAG_W-1:0] t, logic [SITE_IDX_W-1:0] s,
                                    logic [COUNT_W-1:0] c, logic l);
    result_t r;
    r.kind  = k;
    r.tag   = t;
    r.site  = s;
    r.count = c;
    r.last  = l;
    expected_words = {expected_words, r};
  endfunction

  function automatic int eff_weight(int s);
    return (site_weight[s] == 0) ? 1 : site_weight[s];
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ACTIVE_SITES: live_sites = int'(data & 16'h7);
      REG_WEIGHT_0:     site_weight[0] = int'(data);
      REG_WEIGHT_1:     site_weight[1] = int'(data);
      REG_WEIGHT_2:     site_weight[2] = int'(data);
      REG_WEIGHT_3:     site_weight[3] = int'(data);
      default: ;
    endcase
  endfunction

  // expected words for one accepted request
  function automatic void schedule_request(request_t rq);
    int nsites;
    int minw;
    int quota;
    int n;
    int total;
    int slot;
    nsites = (live_sites > SITE_COUNT_DEF) ? SITE_COUNT_DEF : live_sites;
    if (rq.command == CMD_ENQUEUE) begin
      if (int'(rq.site) >= nsites) begin
        push_word(KIND_UNKNOWN_SITE, '0, '0, '0, 1'b1);
      end else if (fifo_fill[rq.site] + int'(rq.copies) > QUEUE_DEPTH_DEF) begin
        push_word(KIND_QUEUE_FULL, '0, '0, '0, 1'b1);
      end else begin
        for (int i = 0; i < int'(rq.copies); i++) begin
          slot = (fifo_head[rq.site] + fifo_fill[rq.site]) % QUEUE_DEPTH_DEF;
          fifo_tag[rq.site][slot] = rq.tag;
          fifo_fill[rq.site]++;
        end
        push_word(KIND_ACCEPTED, '0, '0, '0, 1'b1);
      end
    end else if (nsites == 0) begin
      push_word(KIND_NO_SITES, '0, '0, '0, 1'b1);
    end else begin
      minw = 32'h7fff_ffff;
      total = 0;
      for (int s = 0; s < nsites; s++)
        if (eff_weight(s) < minw) minw = eff_weight(s);
      for (int s = 0; s < nsites; s++) begin
        // round to nearest, halves up
        quota = (2 * eff_weight(s) + minw) / (2 * minw);
        n = (fifo_fill[s] < quota) ? fifo_fill[s] : quota;
        for (int j = 0; j < n; j++) begin
          push_word(KIND_RESPONSE, fifo_tag[s][fifo_head[s]], s[SITE_IDX_W-1:0], '0, 1'b0);
          total++;
          fifo_head[s] = (fifo_head[s] + 1) % QUEUE_DEPTH_DEF;
          fifo_fill[s]--;
        end
      end
      push_word(KIND_ROUND_DONE, '0, '0, total[COUNT_W-1:0], 1'b1);
    end
  endfunction

  function automatic void report_mismatch(string what);
    errors++;
    if (errors <= 10) $display("mismatch: %s", what);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_if.ready) schedule_request(req_word);
      if (!req_valid || req_if.ready) begin
        if (pending_requests.size() != 0 && !(gaps_on && $urandom_range(99) < 9)) begin
          req_word  <= pending_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response ready, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else if (stall_req && !stall_used) begin
      stall_used <= 1'b1;
      stall_left <= 400;
      rsp_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= 1'b0;
    end else begin
      rsp_ready <= !(gaps_on && $urandom_range(99) < 9);
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word kind %0d tag %h site %0d count %0d last %0b, none expected",
                        rsp_if.kind, rsp_if.served_tag, rsp_if.served_site,
                        rsp_if.served_count, rsp_if.last));
      end else begin
        want = expected_words.pop_front();
        if (rsp_if.kind !== want.kind || rsp_if.served_tag !== want.tag ||
            rsp_if.served_site !== want.site || rsp_if.served_count !== want.count ||
            rsp_if.last !== want.last)
          report_mismatch($sformatf(
            "expected kind %0d tag %h site %0d count %0d last %0b, got %0d %h %0d %0d %0b",
            want.kind, want.tag, want.site, want.count, want.last, rsp_if.kind,
            rsp_if.served_tag, rsp_if.served_site, rsp_if.served_count, rsp_if.last));
      end
    end
  end

  function automatic void add_request(logic cmd, logic [TAG_W-1:0] tag,
                                      logic [SITE_IDX_W-1:0] site, logic [COPY_W-1:0] copies);
    request_t rq;
    rq.command = cmd;
    rq.tag     = tag;
    rq.site    = site;
    rq.copies  = copies;
    pending_requests = {pending_requests, rq};
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sites(logic [15:0] act, logic [15:0] w0, logic [15:0] w1,
                           logic [15:0] w2, logic [15:0] w3);
    write_reg(REG_ACTIVE_SITES, act);
    write_reg(REG_WEIGHT_0, w0);
    write_reg(REG_WEIGHT_1, w1);
    write_reg(REG_WEIGHT_2, w2);
    write_reg(REG_WEIGHT_3, w3);
  endtask

  // everything offered, answered, and the block settled
  task automatic wait_idle(int settle);
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || req_valid || expected_words.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_weight();
    if ($urandom_range(3) == 0) return 16'($urandom_range(1, 65535));
    return 16'($urandom_range(0, 6));
  endfunction

  task automatic random_phase(int count);
    int nsites;
    int r;
    nsites = (live_sites > SITE_COUNT_DEF) ? SITE_COUNT_DEF : live_sites;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 30 || nsites == 0)
        add_request(CMD_DEQUEUE, TAG_W'($urandom_range(0, 65535)),
                    SITE_IDX_W'($urandom_range(0, 3)), COPY_W'($urandom_range(0, 15)));
      else if (r < 80)
        add_request(CMD_ENQUEUE, TAG_W'($urandom_range(0, 65535)),
                    SITE_IDX_W'($urandom_range(0, nsites - 1)), COPY_W'($urandom_range(0, 3)));
      else if (r < 92)
        add_request(CMD_ENQUEUE, TAG_W'($urandom_range(0, 65535)),
                    SITE_IDX_W'($urandom_range(0, nsites - 1)), COPY_W'($urandom_range(0, 8)));
      else
        add_request(CMD_ENQUEUE, TAG_W'($urandom_range(0, 65535)),
                    SITE_IDX_W'($urandom_range(0, 3)), COPY_W'($urandom_range(0, 8)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: no sites up
    add_request(CMD_DEQUEUE, 16'h0000, 2'd0, 4'd0);
    add_request(CMD_ENQUEUE, 16'h0001, 2'd0, 4'd1);
    wait_idle(20);

    set_sites(16'd4, 16'd1, 16'd2, 16'd3, 16'd4);
    add_request(CMD_ENQUEUE, 16'hffff, 2'd0, 4'd8);
    add_request(CMD_ENQUEUE, 16'h0001, 2'd0, 4'd1);  // overflow
    add_request(CMD_ENQUEUE, 16'h5555, 2'd1, 4'd0);  // zero copies
    add_request(CMD_ENQUEUE, 16'h8000, 2'd1, 4'd3);
    add_request(CMD_ENQUEUE, 16'h1234, 2'd2, 4'd8);
    add_request(CMD_ENQUEUE, 16'habcd, 2'd3, 4'd5);
    repeat (4) add_request(CMD_DEQUEUE, 16'hffff, 2'd3, 4'd15);
    wait_idle(20);

    // upper data bits ignored, sites 2 and 3 go dark
    set_sites(16'h8002, 16'd2, 16'd3, 16'd1, 16'd1);
    add_request(CMD_ENQUEUE, 16'h0bad, 2'd2, 4'd1);
    add_request(CMD_ENQUEUE, 16'h0f0f, 2'd1, 4'd2);
    add_request(CMD_DEQUEUE, 16'h0000, 2'd0, 4'd0);
    wait_idle(20);

    // more than the site count, zero weight, largest weight
    set_sites(16'd7, 16'd0, 16'd65535, 16'd7, 16'd1);
    add_request(CMD_DEQUEUE, 16'h0000, 2'd0, 4'd0);
    add_request(CMD_DEQUEUE, 16'h0000, 2'd0, 4'd0);
    wait_idle(20);

    set_sites(16'd4, 16'd2, 16'd5, 16'd2, 16'd2);
    write_reg(3'd5, 16'hffff);
    write_reg(3'd6, 16'h0000);
    write_reg(3'd7, 16'h1234);
    add_request(CMD_ENQUEUE, 16'h7777, 2'd1, 4'd6);
    add_request(CMD_DEQUEUE, 16'h0000, 2'd0, 4'd0);
    wait_idle(20);

    for (int p = 0; p < 6; p++) begin
      set_sites((p == 4) ? 16'($urandom_range(5, 7)) : 16'($urandom_range(1, 4)),
                pick_weight(), pick_weight(), pick_weight(), pick_weight());
      gaps_on <= (p != 2);
      if (p == 3) stall_req <= 1'b1;
      random_phase(14);
      wait_idle(20);
    end

    wait_idle(200);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
